// File: design/dbif_pkg.sv
// ----------------------------------------------------------------------------
// dbif_pkg
// Shared types and constants of the double-buffered instruction fetch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dbif_pkg;

   // Fixed address width and fill-length limit
   localparam int ADDR_BITS = 48;
   localparam int MAX_FILL  = 16;

   // Request operation codes
   typedef enum logic {
      OP_FETCH = 1'b0,
      OP_BEAT  = 1'b1
   } op_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_NOT_READY = 2'd1,
      KIND_READ      = 2'd2,
      KIND_UNMATCHED = 2'd3
   } kind_type;

   // Sequencer phases
   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_READS = 5'b00010,
      PH_DATA  = 5'b00100,
      PH_NRDY  = 5'b01000,
      PH_UNM   = 5'b10000
   } phase_type;

   // One result on its way from the sequencer to the response stage
   typedef struct packed {
      kind_type               kind;
      logic [3:0]             valid_bytes;
      logic [2:0]             byte_off;
      logic                   zero0;
      logic                   zero1;
      logic [ADDR_BITS-1:0]   read_addr;
      logic [3:0]             read_generation;
      logic [3:0]             read_line;
      logic                   last;
   } dbif_desc_type;

endpackage

`default_nettype wire

// File: design/dbif_req_if.sv
// ----------------------------------------------------------------------------
// dbif_req_if
// Request channel: fetch requests and memory line-data beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbif_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [47:0] fetch_addr;
   logic [4:0]  fill_len;
   logic [3:0]  beat_generation;
   logic [3:0]  beat_line;
   logic [2:0]  beat_word;
   logic [63:0] beat_data;
   logic        beat_last;

   modport source (output valid, op, fetch_addr, fill_len, beat_generation, beat_line,
                   beat_word, beat_data, beat_last, input ready);
   modport sink   (input valid, op, fetch_addr, fill_len, beat_generation, beat_line,
                   beat_word, beat_data, beat_last, output ready);
endinterface

`default_nettype wire

// File: design/dbif_rsp_if.sv
// ----------------------------------------------------------------------------
// dbif_rsp_if
// Response channel: fetch data, not-ready, line read requests, errors.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbif_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] fetch_bytes;
   logic [3:0]  valid_bytes;
   logic [47:0] read_addr;
   logic [3:0]  read_generation;
   logic [3:0]  read_line;
   logic        last;

   modport source (output valid, kind, fetch_bytes, valid_bytes, read_addr,
                   read_generation, read_line, last, input ready);
   modport sink   (input valid, kind, fetch_bytes, valid_bytes, read_addr,
                   read_generation, read_line, last, output ready);
endinterface

`default_nettype wire

// File: design/dbif_rsp_stage.sv
// ----------------------------------------------------------------------------
// dbif_rsp_stage
// Aligns buffer words into fetch bytes; a stage-one and an output register
// hold results, so the sequencer runs on in a receiver stall until both fill.
// ----------------------------------------------------------------------------
`default_nettype none

module dbif_rsp_stage
   import dbif_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire dbif_desc_type push_desc,
   input  wire logic [63:0]   rd_word0,
   input  wire logic [63:0]   rd_word1,
   output logic               push_ok,
   dbif_rsp_if.source         rsp
);

   logic          s1_vld_ff, s1_vld_in;
   dbif_desc_type s1_ff;
   logic          out_vld_ff, out_vld_in;
   logic          out_adv, s1_adv;

   logic [1:0]    out_kind_ff;
   logic [63:0]   out_bytes_ff, bytes_in;
   logic [3:0]    out_valid_ff;
   logic [47:0]   out_addr_ff;
   logic [3:0]    out_gen_ff;
   logic [3:0]    out_line_ff;
   logic          out_last_ff;

   logic [63:0]   w0, w1, mask;
   logic [127:0]  cat;

   // Advance when the next stage has room
   assign out_adv = !out_vld_ff || rsp.ready;
   assign s1_adv  = s1_vld_ff && out_adv;
   assign push_ok = !s1_vld_ff || out_adv;

   always_comb begin
      s1_vld_in  = push ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);
      out_vld_in = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_ff);
   end

   // Select the bytes of the window and drop those past the count
   always_comb begin
      w0   = s1_ff.zero0 ? 64'd0 : rd_word0;
      w1   = s1_ff.zero1 ? 64'd0 : rd_word1;
      cat  = {w1, w0} >> {s1_ff.byte_off, 3'b000};
      if (s1_ff.valid_bytes >= 4'd8) begin
         mask = '1;
      end else begin
         mask = (64'd1 << {s1_ff.valid_bytes[2:0], 3'b000}) - 64'd1;
      end
      bytes_in = cat[63:0] & mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (push) begin
         s1_ff <= push_desc;
      end
      if (s1_adv) begin
         out_kind_ff  <= s1_ff.kind;
         out_bytes_ff <= bytes_in;
         out_valid_ff <= s1_ff.valid_bytes;
         out_addr_ff  <= s1_ff.read_addr;
         out_gen_ff   <= s1_ff.read_generation;
         out_line_ff  <= s1_ff.read_line;
         out_last_ff  <= s1_ff.last;
      end
   end

   assign rsp.valid           = out_vld_ff;
   assign rsp.kind            = out_kind_ff;
   assign rsp.fetch_bytes     = out_bytes_ff;
   assign rsp.valid_bytes     = out_valid_ff;
   assign rsp.read_addr       = out_addr_ff;
   assign rsp.read_generation = out_gen_ff;
   assign rsp.read_line       = out_line_ff;
   assign rsp.last            = out_last_ff;

endmodule

`default_nettype wire

// File: design/double_buffered_instruction_fetch.sv
// ----------------------------------------------------------------------------
// double_buffered_instruction_fetch
// Instruction fetch unit with a current and a next buffer of cache lines.
// ----------------------------------------------------------------------------
// Usage: req_chan carries fetch requests (op 0) and memory line-data beats
// (op 1); rsp_chan returns fetch data beats of up to 8 bytes, not-ready
// answers, line read requests and unmatched-beat errors, with last set on the
// final result of each item. Both channels use valid/ready.
// An accepted item is registered into the sequencer job; its results then
// pass the response stage's stage-one and output registers. Throughput: one
// result per cycle out of the sequencer while the response stage has room;
// a rotation or miss first gives LINES_PER_BUFFER line reads, then data or
// a not-ready. The next item is accepted in the cycle its predecessor pushes
// its final result. Data beats read two words per cycle from buffer memory.
// Reset: bases, select, pending mask and generation clear; per-word valid
// bits make the buffer memory read as zero until written.
// Stall: results wait in a two-entry response pipe; once both are full the
// sequencer holds and req_chan.ready drops while it has a result to push.
// LINE_BYTES and LINES_PER_BUFFER must be powers of two.
// ----------------------------------------------------------------------------
`default_nettype none

module double_buffered_instruction_fetch
   import dbif_pkg::*;
#(
   parameter int LINE_BYTES       = 64,
   parameter int LINES_PER_BUFFER = 2
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   dbif_req_if.sink   req_chan,
   dbif_rsp_if.source rsp_chan
);

   localparam int WORDS_PER_LINE = LINE_BYTES / 8;
   localparam int BUF_WORDS      = WORDS_PER_LINE * LINES_PER_BUFFER;
   localparam int BUF_BYTES      = LINE_BYTES * LINES_PER_BUFFER;
   localparam int BOFF_W         = $clog2(BUF_BYTES);
   localparam int MEM_DEPTH      = 2 * BUF_WORDS;
   localparam int MA_W           = $clog2(MEM_DEPTH);
   localparam int WX_W           = MA_W + 1;
   localparam logic [MA_W-1:0] LOCAL_MASK = MA_W'(BUF_WORDS - 1);

   // Architectural state
   logic [ADDR_BITS-1:0]        cur_base_ff, cur_base_in;
   logic [ADDR_BITS-1:0]        nxt_base_ff, nxt_base_in;
   logic                        sel_ff, sel_in;
   logic [LINES_PER_BUFFER-1:0] pending_ff, pending_in;
   logic [3:0]                  gen_ff, gen_in;

   // Sequencer job
   phase_type                   phase_ff, phase_in;
   logic                        then_data_ff, then_data_in;
   logic [3:0]                  rd_cnt_ff, rd_cnt_in;
   logic [ADDR_BITS-1:0]        job_addr_ff, job_addr_in;
   logic [3:0]                  job_gen_ff, job_gen_in;
   logic [BOFF_W-1:0]           job_off_ff, job_off_in;
   logic [4:0]                  job_len_ff, job_len_in;
   logic                        job_beat_ff, job_beat_in;
   logic                        job_sel_ff, job_sel_in;

   // Buffer memory
   logic [63:0]                 mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]        vld_ff;
   logic [63:0]                 rd0_ff, rd1_ff;
   logic                        mem_we, rd_en;
   logic [MA_W-1:0]             wr_addr, rd_a0, rd_a1;

   logic                        accept, push, push_ok, job_done, final_beat;
   dbif_desc_type               desc;

   logic [ADDR_BITS-1:0]        off_c, off_n, new_next;
   logic                        hit_c, hit_n, gen_ok, line_pend, word_ok;
   logic [4:0]                  len;
   logic [LINES_PER_BUFFER-1:0] line_bit;
   logic [BOFF_W:0]             off_w;
   logic [WX_W-1:0]             widx0, widx1;
   logic [3:0]                  nbytes;

   assign accept = req_chan.valid && req_chan.ready;
   assign push   = (phase_ff != PH_IDLE) && push_ok;

   // Fetch window tests against both buffers
   always_comb begin
      off_c    = req_chan.fetch_addr - cur_base_ff;
      off_n    = req_chan.fetch_addr - nxt_base_ff;
      hit_c    = (off_c[ADDR_BITS-1:BOFF_W] == '0);
      hit_n    = (off_n[ADDR_BITS-1:BOFF_W] == '0);
      new_next = {req_chan.fetch_addr[ADDR_BITS-1:BOFF_W], BOFF_W'(0)};
      len      = (req_chan.fill_len > 5'(MAX_FILL)) ? 5'(MAX_FILL) : req_chan.fill_len;
      gen_ok   = (req_chan.beat_generation == gen_ff);
      line_bit = LINES_PER_BUFFER'(1) << req_chan.beat_line;
      line_pend = |(pending_ff & line_bit);
      word_ok  = (int'(req_chan.beat_word) < WORDS_PER_LINE);
      wr_addr  = MA_W'(BUF_WORDS * int'(!sel_ff) + WORDS_PER_LINE * int'(req_chan.beat_line)
                       + int'(req_chan.beat_word));
   end

   // Word addresses and byte count of the current data beat
   always_comb begin
      off_w      = {1'b0, job_off_ff} + (BOFF_W+1)'({job_beat_ff, 3'b000});
      widx0      = WX_W'(off_w >> 3);
      widx1      = widx0 + WX_W'(1);
      rd_a0      = (MA_W'(widx0) & LOCAL_MASK) | (MA_W'(job_sel_ff) << (MA_W - 1));
      rd_a1      = (MA_W'(widx1) & LOCAL_MASK) | (MA_W'(job_sel_ff) << (MA_W - 1));
      final_beat = job_beat_ff || (job_len_ff <= 5'd8);
      if (job_beat_ff) begin
         nbytes = 4'(job_len_ff - 5'd8);
      end else if (job_len_ff > 5'd8) begin
         nbytes = 4'd8;
      end else begin
         nbytes = job_len_ff[3:0];
      end
   end

   // Sequencer: emit one result a cycle while the response stage has room, take new items and update state
   always_comb begin
      cur_base_in  = cur_base_ff;
      nxt_base_in  = nxt_base_ff;
      sel_in       = sel_ff;
      pending_in   = pending_ff;
      gen_in       = gen_ff;
      phase_in     = phase_ff;
      then_data_in = then_data_ff;
      rd_cnt_in    = rd_cnt_ff;
      job_addr_in  = job_addr_ff;
      job_gen_in   = job_gen_ff;
      job_off_in   = job_off_ff;
      job_len_in   = job_len_ff;
      job_beat_in  = job_beat_ff;
      job_sel_in   = job_sel_ff;
      desc         = '0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      job_done     = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
         end
         PH_READS: begin
            desc.kind            = KIND_READ;
            desc.read_addr       = job_addr_ff;
            desc.read_generation = job_gen_ff;
            desc.read_line       = rd_cnt_ff;
            if (push) begin
               job_addr_in = job_addr_ff + ADDR_BITS'(LINE_BYTES);
               rd_cnt_in   = rd_cnt_ff + 4'd1;
               if (rd_cnt_ff == 4'(LINES_PER_BUFFER - 1)) begin
                  rd_cnt_in = 4'd0;
                  phase_in  = then_data_ff ? PH_DATA : PH_NRDY;
               end
            end
         end
         PH_DATA: begin
            desc.kind        = KIND_DATA;
            desc.valid_bytes = nbytes;
            desc.byte_off    = job_off_ff[2:0];
            desc.zero0       = (widx0 >= WX_W'(BUF_WORDS)) || !vld_ff[rd_a0];
            desc.zero1       = (widx1 >= WX_W'(BUF_WORDS)) || !vld_ff[rd_a1];
            desc.last        = final_beat;
            if (push) begin
               rd_en = 1'b1;
               if (final_beat) begin
                  phase_in = PH_IDLE;
                  job_done = 1'b1;
               end else begin
                  job_beat_in = 1'b1;
               end
            end
         end
         PH_NRDY, PH_UNM: begin
            desc.kind = (phase_ff == PH_NRDY) ? KIND_NOT_READY : KIND_UNMATCHED;
            desc.last = 1'b1;
            if (push) begin
               phase_in = PH_IDLE;
               job_done = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Take a new item
      if (accept) begin
         job_beat_in = 1'b0;
         job_len_in  = len;
         rd_cnt_in   = 4'd0;
         if (req_chan.op == OP_FETCH) begin
            priority if (hit_c) begin
               phase_in   = PH_DATA;
               job_off_in = off_c[BOFF_W-1:0];
               job_sel_in = sel_ff;
            end else if (hit_n && (pending_ff == '0)) begin
               sel_in       = !sel_ff;
               cur_base_in  = nxt_base_ff;
               nxt_base_in  = nxt_base_ff + ADDR_BITS'(BUF_BYTES);
               pending_in   = '1;
               phase_in     = PH_READS;
               then_data_in = 1'b1;
               job_addr_in  = nxt_base_ff + ADDR_BITS'(BUF_BYTES);
               job_gen_in   = gen_ff;
               job_off_in   = off_n[BOFF_W-1:0];
               job_sel_in   = !sel_ff;
            end else if (hit_n) begin
               phase_in = PH_NRDY;
            end else begin
               nxt_base_in  = new_next;
               gen_in       = gen_ff + 4'd1;
               pending_in   = '1;
               phase_in     = PH_READS;
               then_data_in = 1'b0;
               job_addr_in  = new_next;
               job_gen_in   = gen_ff + 4'd1;
            end
         end else begin
            phase_in = PH_IDLE;
            if (gen_ok) begin
               if (!line_pend) begin
                  phase_in = PH_UNM;
               end else begin
                  mem_we = word_ok;
                  if (req_chan.beat_last) begin
                     pending_in = pending_ff & ~line_bit;
                  end
               end
            end
         end
      end
   end

   assign req_chan.ready = (phase_ff == PH_IDLE) || job_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_base_ff  <= '0;
         nxt_base_ff  <= '0;
         sel_ff       <= 1'b0;
         pending_ff   <= '0;
         gen_ff       <= '0;
         phase_ff     <= PH_IDLE;
         then_data_ff <= 1'b0;
         rd_cnt_ff    <= '0;
         job_beat_ff  <= 1'b0;
      end else begin
         cur_base_ff  <= cur_base_in;
         nxt_base_ff  <= nxt_base_in;
         sel_ff       <= sel_in;
         pending_ff   <= pending_in;
         gen_ff       <= gen_in;
         phase_ff     <= phase_in;
         then_data_ff <= then_data_in;
         rd_cnt_ff    <= rd_cnt_in;
         job_beat_ff  <= job_beat_in;
      end
   end

   // Job payload
   always_ff @(posedge clock) begin
      job_addr_ff <= job_addr_in;
      job_gen_ff  <= job_gen_in;
      job_off_ff  <= job_off_in;
      job_len_ff  <= job_len_in;
      job_sel_ff  <= job_sel_in;
   end

   // Mark written words; unwritten words read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Buffer memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_chan.beat_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff <= mem[rd_a0];
         rd1_ff <= mem[rd_a1];
      end
   end

   dbif_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (desc),
      .rd_word0  (rd0_ff),
      .rd_word1  (rd1_ff),
      .push_ok   (push_ok),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

// File: test/dbif_tb_if.sv
// ----------------------------------------------------------------------------
// dbif_tb_if
// Testbench-side notes: the channel interfaces come from the design folder;
// this file holds the shared item types used by the fetch-unit checker.
// ----------------------------------------------------------------------------
package dbif_tb_pkg;
   import dbif_pkg::*;

   // One result item as seen on the response channel
   typedef struct packed {
      kind_type    kind;
      logic [63:0] fetch_bytes;
      logic [3:0]  valid_bytes;
      logic [47:0] read_addr;
      logic [3:0]  read_generation;
      logic [3:0]  read_line;
      logic        last;
   } fetch_rsp_type;

   // One request item as driven on the request channel
   typedef struct packed {
      op_type      op;
      logic [47:0] fetch_addr;
      logic [4:0]  fill_len;
      logic [3:0]  beat_generation;
      logic [3:0]  beat_line;
      logic [2:0]  beat_word;
      logic [63:0] beat_data;
      logic        beat_last;
   } fetch_req_type;
endpackage

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-buffered instruction fetch unit: a
// predictor tracks both buffers, pending lines and generation, and a
// scoreboard compares every response item in order under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import dbif_pkg::*;
   import dbif_tb_pkg::*;

   localparam int LINE_B    = 64;
   localparam int LINES     = 2;
   localparam int WPL       = LINE_B / 8;
   localparam int BUF_W     = WPL * LINES;
   localparam int BUF_B     = LINE_B * LINES;
   localparam int CYCLE_CAP = 400000;

   // Fetch-unit predictor plus queue of expected responses
   class fetch_scoreboard;
      logic [47:0] cur_base, nxt_base;
      logic [63:0] store [2*BUF_W];
      bit          sel;
      bit [LINES-1:0] pending;
      logic [3:0]  gen;
      fetch_rsp_type expected_rsps[$];
      int          errors;
      int          checked;

      function void clear();
         cur_base = '0; nxt_base = '0; sel = 0; pending = '0; gen = '0;
         foreach (store[i]) store[i] = '0;
         expected_rsps.delete();
      endfunction

      function void push(kind_type k, logic [63:0] b, logic [3:0] v,
                         logic [47:0] a, logic [3:0] g, logic [3:0] l);
         fetch_rsp_type r;
         r.kind = k; r.fetch_bytes = b; r.valid_bytes = v; r.read_addr = a;
         r.read_generation = g; r.read_line = l; r.last = 0;
         expected_rsps.insert(expected_rsps.size(), r);
      endfunction

      function logic [7:0] buf_byte(bit s, logic [47:0] b);
         int w;
         if (b >= BUF_B) return 8'h00;
         w = s * BUF_W + (b / LINE_B) * WPL + (b % LINE_B) / 8;
         return store[w][(b % 8)*8 +: 8];
      endfunction

      function void post_line_reads();
         for (int i = 0; i < LINES; i++)
            push(KIND_READ, '0, '0, nxt_base + 48'(i * LINE_B), gen, 4'(i));
         pending = '1;
      endfunction

      function void post_data(logic [47:0] off, int len);
         int done, n;
         logic [63:0] b;
         done = 0;
         do begin
            n = len - done;
            if (n > 8) n = 8;
            b = '0;
            for (int i = 0; i < n; i++)
               b[i*8 +: 8] = buf_byte(sel, off + 48'(done + i));
            push(KIND_DATA, b, 4'(n), '0, '0, '0);
            done += n;
         end while (done < len);
      endfunction

      // Note an accepted request and predict its responses
      function void note_request(fetch_req_type q);
         int prior_count, len;
         logic [47:0] oc, on;
         prior_count = expected_rsps.size();
         if (q.op == OP_FETCH) begin
            len = q.fill_len > MAX_FILL ? MAX_FILL : q.fill_len;
            oc = q.fetch_addr - cur_base;
            on = q.fetch_addr - nxt_base;
            if (oc < BUF_B) begin
               post_data(oc, len);
            end else if (on < BUF_B) begin
               if (pending == 0) begin
                  sel = ~sel;
                  cur_base = nxt_base;
                  nxt_base = cur_base + 48'(BUF_B);
                  post_line_reads();
                  post_data(on, len);
               end else begin
                  push(KIND_NOT_READY, '0, '0, '0, '0, '0);
               end
            end else begin
               nxt_base = q.fetch_addr - (q.fetch_addr % BUF_B);
               gen = gen + 4'd1;
               post_line_reads();
               push(KIND_NOT_READY, '0, '0, '0, '0, '0);
            end
         end else if (q.beat_generation == gen) begin
            if (q.beat_line >= LINES || !pending[q.beat_line]) begin
               push(KIND_UNMATCHED, '0, '0, '0, '0, '0);
            end else begin
               if (q.beat_word < WPL)
                  store[(!sel) * BUF_W + q.beat_line * WPL + q.beat_word] = q.beat_data;
               if (q.beat_last) pending[q.beat_line] = 0;
            end
         end
         if (expected_rsps.size() > prior_count)
            expected_rsps[expected_rsps.size()-1].last = 1;
      endfunction

      // Compare one response item with the oldest expectation
      function void check_response(fetch_rsp_type got);
         fetch_rsp_type e;
         checked++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         e = expected_rsps.pop_front();
         if (got.kind != e.kind)
            $display("%0t: kind expected %0d actual %0d", $time, e.kind, got.kind);
         if (got.fetch_bytes != e.fetch_bytes)
            $display("%0t: fetch_bytes expected %h actual %h", $time, e.fetch_bytes,
                     got.fetch_bytes);
         if (got.valid_bytes != e.valid_bytes)
            $display("%0t: valid_bytes expected %0d actual %0d", $time, e.valid_bytes,
                     got.valid_bytes);
         if (got.read_addr != e.read_addr)
            $display("%0t: read_addr expected %h actual %h", $time, e.read_addr,
                     got.read_addr);
         if (got.read_generation != e.read_generation)
            $display("%0t: read_generation expected %0d actual %0d", $time,
                     e.read_generation, got.read_generation);
         if (got.read_line != e.read_line)
            $display("%0t: read_line expected %0d actual %0d", $time, e.read_line,
                     got.read_line);
         if (got.last != e.last)
            $display("%0t: last expected %0d actual %0d", $time, e.last, got.last);
         if (got !== e) errors++;
      endfunction
   endclass

   logic clock, reset;
   dbif_req_if req_chan();
   dbif_rsp_if rsp_chan();

   double_buffered_instruction_fetch uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   fetch_scoreboard sb;
   int  idle_pct, stall_pct, hold_cycles;
   bit  timed_out;
   int  n_items, n_rotations, n_misses;
   int  goal;
   logic [47:0] walk_addr;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Response side: random stall, long hold-off on request, scoreboard check
   initial begin
      rsp_chan.ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_response({kind_type'(rsp_chan.kind), rsp_chan.fetch_bytes,
                               rsp_chan.valid_bytes, rsp_chan.read_addr,
                               rsp_chan.read_generation, rsp_chan.read_line,
                               rsp_chan.last});
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_chan.ready <= 0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Cycle limit
   initial begin
      repeat (CYCLE_CAP) @(posedge clock);
      timed_out = 1;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offer one item and hold it until accepted
   task automatic send(fetch_req_type q);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid           <= 1;
      req_chan.op              <= q.op;
      req_chan.fetch_addr      <= q.fetch_addr;
      req_chan.fill_len        <= q.fill_len;
      req_chan.beat_generation <= q.beat_generation;
      req_chan.beat_line       <= q.beat_line;
      req_chan.beat_word       <= q.beat_word;
      req_chan.beat_data       <= q.beat_data;
      req_chan.beat_last       <= q.beat_last;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(q);
      n_items++;
   endtask

   task automatic fetch(logic [47:0] a, logic [4:0] len);
      fetch_req_type q;
      q = '0; q.op = OP_FETCH; q.fetch_addr = a; q.fill_len = len;
      if (a - sb.nxt_base < BUF_B && a - sb.cur_base >= BUF_B && sb.pending == 0)
         n_rotations++;
      else if (a - sb.nxt_base >= BUF_B && a - sb.cur_base >= BUF_B)
         n_misses++;
      send(q);
   endtask

   task automatic beat(logic [3:0] g, logic [3:0] l, logic [2:0] w, logic [63:0] d,
                       logic lst);
      fetch_req_type q;
      q = '0; q.op = OP_BEAT; q.beat_generation = g; q.beat_line = l;
      q.beat_word = w; q.beat_data = d; q.beat_last = lst;
      send(q);
   endtask

   // Fill every line of the next buffer with random words
   task automatic fill_next();
      for (int l = 0; l < LINES; l++)
         for (int w = 0; w < WPL; w++)
            beat(sb.gen, 4'(l), 3'(w), {$urandom, $urandom}, w == WPL - 1);
   endtask

   // Stop offering and wait for every expected item
   task automatic drain();
      req_chan.valid <= 0;
      while (sb.expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [47:0] rand_addr();
      return 48'({$urandom, $urandom});
   endfunction

   // One random item: mostly well-formed walks, some noise
   task automatic random_item();
      int r;
      r = $urandom_range(99);
      if (r < 30) begin
         fetch(sb.cur_base + 48'($urandom_range(BUF_B - 1)), 5'($urandom_range(31)));
      end else if (r < 45) begin
         fetch(sb.nxt_base + 48'($urandom_range(BUF_B - 1)), 5'($urandom_range(16)));
      end else if (r < 70) begin
         if (sb.pending != 0) fill_next();
         else fetch(sb.nxt_base + 48'($urandom_range(BUF_B - 1)), 5'($urandom_range(16)));
      end else if (r < 80) begin
         fetch(rand_addr(), 5'($urandom_range(31)));
      end else if (r < 88) begin
         beat(sb.gen, 4'($urandom_range(15)), 3'($urandom_range(7)),
              {$urandom, $urandom}, 1'($urandom));
      end else begin
         beat(4'($urandom_range(15)), 4'($urandom_range(3)), 3'($urandom_range(7)),
              {$urandom, $urandom}, 1'($urandom));
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      idle_pct = 0; stall_pct = 0; hold_cycles = 0; timed_out = 0;
      reset = 1;
      req_chan.valid <= 0; req_chan.op <= OP_FETCH; req_chan.fetch_addr <= '0;
      req_chan.fill_len <= '0; req_chan.beat_generation <= '0; req_chan.beat_line <= '0;
      req_chan.beat_word <= '0; req_chan.beat_data <= '0; req_chan.beat_last <= '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: cleared buffers, length extremes, wrap, miss, fills, rotation
      fetch(48'h0, 5'd0);
      fetch(48'h7F, 5'd31);
      fetch(48'h78, 5'd16);
      fetch(48'h80, 5'd8);
      fetch(48'hFFFF_FFFF_FFF0, 5'd16);
      fetch(48'hFFFF_FFFF_FFF8, 5'd1);
      beat(4'd0, 4'd0, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      beat(sb.gen, 4'd0, 3'd7, 64'h0123_4567_89AB_CDEF, 1'b0);
      beat(sb.gen, 4'd15, 3'd0, 64'h0, 1'b1);
      beat(sb.gen, 4'd2, 3'd0, 64'h0, 1'b0);
      fill_next();
      beat(sb.gen, 4'd0, 3'd0, 64'h0, 1'b1);
      fetch(48'hFFFF_FFFF_FF80, 5'd16);
      fetch(48'hFFFF_FFFF_FFFF, 5'd16);
      fill_next();
      fetch(48'h0, 5'd16);
      drain();

      // Long receiver hold-off while the sender keeps offering items
      hold_cycles = 60;
      goal = n_items + 12;
      while (n_items < goal) random_item();
      drain();

      for (int p = 0; p < 4; p++) begin
         idle_pct  = (p == 1 || p == 3) ? (p == 1 ? 59 : 14) : 0;
         stall_pct = (p == 2 || p == 3) ? (p == 2 ? 59 : 14) : 0;
         goal = n_items + 90;
         while (n_items < goal) random_item();
         drain();
      end

      $display("Covered %0d items with %0d rotations and %0d misses, %0d responses checked.",
               n_items, n_rotations, n_misses, sb.checked);
      if (sb.errors == 0 && sb.expected_rsps.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// File: double_buffered_instruction_fetch.f
design/dbif_pkg.sv
design/dbif_req_if.sv
design/dbif_rsp_if.sv
design/dbif_rsp_stage.sv
design/double_buffered_instruction_fetch.sv
test/dbif_tb_if.sv
test/tb_top.sv
